[hw/rtl/brainfuck_bytecode_executor_top_macros.svh]
// Assertion helpers for the bytecode executor.
`ifndef BRAINFUCK_BYTECODE_EXECUTOR_TOP_MACROS_SVH
`define BRAINFUCK_BYTECODE_EXECUTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BBE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BBE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BBE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BBE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/bbe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bbe_pkg;

  // Both depths must be powers of two.
  localparam int unsigned TapeDepthDefault    = 32768;
  localparam int unsigned ProgramDepthDefault = 65536;

  typedef enum logic [3:0] {
    OP_ADD_BYTE = 4'd0,
    OP_SUB_BYTE = 4'd1,
    OP_ADD_PTR  = 4'd2,
    OP_SUB_PTR  = 4'd3,
    OP_WRITE    = 4'd4,
    OP_READ     = 4'd5,
    OP_JUMP_Z   = 4'd6,
    OP_JUMP     = 4'd7,
    OP_END      = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0,
    ST_END = 2'd1,
    ST_BAD = 2'd2
  } status_e;

  // Instruction as it leaves the pointer stage.
  typedef struct packed {
    op_e         op;
    logic [7:0]  amount_lo;
    logic [15:0] target;
    logic [7:0]  in_byte;
    logic        range_err;
  } s1_t;

endpackage

`default_nettype wire

[hw/rtl/bbe_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read during write to the same entry returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bbe_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bbe_front #(
  parameter int unsigned TAPE_DEPTH = 32768
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [3:0]                    operation_i,
  input  wire logic [15:0]                   amount_i,
  input  wire logic [15:0]                   jump_target_i,
  input  wire logic [7:0]                    input_byte_i,
  input  wire logic                          s1_ready_i,
  output logic                               s1_valid_o,
  output bbe_pkg::s1_t                       s1_o,
  output logic [$clog2(TAPE_DEPTH)-1:0]      s1_ptr_o,
  output logic                               rd_en_o,
  output logic [$clog2(TAPE_DEPTH)-1:0]      rd_addr_o,
  output logic                               clearing_o,
  output logic [$clog2(TAPE_DEPTH)-1:0]      clr_addr_o
);

  import bbe_pkg::*;

  localparam int unsigned PW = $clog2(TAPE_DEPTH);

  logic          clearing_q, clearing_d;
  logic [PW-1:0] clr_cnt_q, clr_cnt_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic          s1_valid_q, s1_valid_d;
  s1_t           s1_q, s1_d;
  logic [PW-1:0] s1_ptr_q, s1_ptr_d;
  logic          in_fire;
  logic [16:0]   ptr_sum;
  logic          rerr;
  op_e           op;

  assign op         = op_e'(operation_i);
  assign in_ready_o = !clearing_q && (!s1_valid_q || s1_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ptr_sum    = 17'(amount_i) + 17'(ptr_q);

  // Pointer moves do not depend on the tape, so they settle at accept time.
  always_comb begin
    ptr_d = ptr_q;
    rerr  = 1'b0;
    case (op)
      OP_ADD_PTR: begin
        rerr  = (ptr_sum >> PW) != 17'd0;
        ptr_d = ptr_sum[PW-1:0];
      end
      OP_SUB_PTR: begin
        rerr  = amount_i > 16'(ptr_q);
        ptr_d = ptr_q - amount_i[PW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + PW'(1);
      if (clr_cnt_q == PW'(TAPE_DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    s1_ptr_d   = s1_ptr_q;
    if (in_fire) begin
      s1_valid_d       = 1'b1;
      s1_d.op          = op;
      s1_d.amount_lo   = amount_i[7:0];
      s1_d.target      = jump_target_i;
      s1_d.in_byte     = input_byte_i;
      s1_d.range_err   = rerr;
      s1_ptr_d         = ptr_q;
    end else if (s1_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      ptr_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
      s1_valid_q <= s1_valid_d;
      if (in_fire) begin
        ptr_q <= ptr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q     <= s1_d;
    s1_ptr_q <= s1_ptr_d;
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;
  assign s1_ptr_o   = s1_ptr_q;
  assign rd_en_o    = in_fire;
  assign rd_addr_o  = ptr_q;
  assign clearing_o = clearing_q;
  assign clr_addr_o = clr_cnt_q;

endmodule

`default_nettype wire

[hw/rtl/bbe_exec.sv]
`timescale 1ns / 1ps
`default_nettype none

module bbe_exec #(
  parameter int unsigned TAPE_DEPTH    = 32768,
  parameter int unsigned PROGRAM_DEPTH = 65536
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s1_valid_i,
  output logic                               s1_ready_o,
  input  wire bbe_pkg::s1_t                  s1_i,
  input  wire logic [$clog2(TAPE_DEPTH)-1:0] s1_ptr_i,
  input  wire logic [7:0]                    rd_data_i,
  output logic                               wr_en_o,
  output logic [$clog2(TAPE_DEPTH)-1:0]      wr_addr_o,
  output logic [7:0]                         wr_data_o,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output logic [15:0]                        next_address_o,
  output logic [7:0]                         out_byte_o,
  output logic                               out_valid_o,
  output logic                               range_error_o,
  output logic [1:0]                         status_o
);

  import bbe_pkg::*;

  localparam int unsigned PW = $clog2(TAPE_DEPTH);
  localparam int unsigned AW = $clog2(PROGRAM_DEPTH);

  logic          fire;
  logic [7:0]    cur_byte;
  logic [7:0]    new_cell;
  logic          cell_we;
  logic [AW-1:0] here_q, next_d;
  logic [7:0]    obyte_d;
  logic          ovalid_d;
  status_e       status_d;

  logic          fwd_valid_q;
  logic [PW-1:0] fwd_addr_q;
  logic [7:0]    fwd_data_q;

  logic          res_valid_q;
  logic [AW-1:0] res_next_q;
  logic [7:0]    res_byte_q;
  logic          res_ovalid_q;
  logic          res_rerr_q;
  status_e       res_status_q;

  assign s1_ready_o = !res_valid_q || res_ready_i;
  assign fire       = s1_valid_i && s1_ready_o;

  // The read was issued in the cycle the previous word may have written.
  assign cur_byte = (fwd_valid_q && fwd_addr_q == s1_ptr_i) ? fwd_data_q : rd_data_i;

  always_comb begin
    new_cell = cur_byte;
    cell_we  = 1'b0;
    next_d   = here_q + AW'(1);
    obyte_d  = 8'd0;
    ovalid_d = 1'b0;
    status_d = ST_RUN;
    unique case (s1_i.op) inside
      OP_ADD_BYTE: begin
        new_cell = cur_byte + s1_i.amount_lo;
        cell_we  = 1'b1;
      end
      OP_SUB_BYTE: begin
        new_cell = cur_byte - s1_i.amount_lo;
        cell_we  = 1'b1;
      end
      OP_ADD_PTR, OP_SUB_PTR: ;
      OP_WRITE: begin
        obyte_d  = cur_byte;
        ovalid_d = 1'b1;
      end
      OP_READ: begin
        new_cell = s1_i.in_byte;
        cell_we  = 1'b1;
      end
      OP_JUMP_Z: begin
        if (cur_byte == 8'd0) begin
          next_d = s1_i.target[AW-1:0];
        end
      end
      OP_JUMP: begin
        next_d = s1_i.target[AW-1:0];
      end
      OP_END: begin
        status_d = ST_END;
        next_d   = here_q;
      end
      default: begin
        status_d = ST_BAD;
        next_d   = here_q;
      end
    endcase
  end

  assign wr_en_o   = fire && cell_we;
  assign wr_addr_o = s1_ptr_i;
  assign wr_data_o = new_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      here_q      <= '0;
      fwd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        here_q      <= next_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (wr_en_o) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_o) begin
      fwd_addr_q <= s1_ptr_i;
      fwd_data_q <= new_cell;
    end
    if (fire) begin
      res_next_q   <= next_d;
      res_byte_q   <= obyte_d;
      res_ovalid_q <= ovalid_d;
      res_rerr_q   <= s1_i.range_err;
      res_status_q <= status_d;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign next_address_o = 16'(res_next_q);
  assign out_byte_o     = res_byte_q;
  assign out_valid_o    = res_ovalid_q;
  assign range_error_o  = res_rerr_q;
  assign status_o       = res_status_q;

endmodule

`default_nettype wire

[hw/rtl/brainfuck_bytecode_executor_top.sv]
// Channel  Handshake                  Word fields
// in       in_valid_i / in_ready_o    operation, amount, jump_target, input_byte
// result   res_valid_o / res_ready_i  next_address, out_byte, out_valid,
//                                     range_error, status
//
// One word per cycle sustained while res_ready_i is high. Rate is set by the tape
// RAM read-modify-write: read at accept; write back and result register load as
// the word leaves the pointer stage, with a one-entry bypass for back-to-back hits
// on a cell. After reset every tape cell is zeroed, one cell a cycle, with
// in_ready_o low. A stalled result holds the pointer stage, which holds input.
// TAPE_DEPTH and PROGRAM_DEPTH must be powers of two; the block does not check it.
`timescale 1ns / 1ps
`default_nettype none
`include "brainfuck_bytecode_executor_top_macros.svh"

module brainfuck_bytecode_executor_top #(
  parameter int unsigned TAPE_DEPTH    = bbe_pkg::TapeDepthDefault,
  parameter int unsigned PROGRAM_DEPTH = bbe_pkg::ProgramDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  operation_i,
  input  wire logic [15:0] amount_i,
  input  wire logic [15:0] jump_target_i,
  input  wire logic [7:0]  input_byte_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [15:0]      next_address_o,
  output logic [7:0]       out_byte_o,
  output logic             out_valid_o,
  output logic             range_error_o,
  output logic [1:0]       status_o
);

  import bbe_pkg::*;

  localparam int unsigned PW = $clog2(TAPE_DEPTH);

  logic          s1_valid, s1_ready;
  s1_t           s1;
  logic [PW-1:0] s1_ptr;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          clearing;
  logic [PW-1:0] clr_addr;
  logic          ex_we;
  logic [PW-1:0] ex_waddr;
  logic [7:0]    ex_wdata;
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  bbe_front #(
    .TAPE_DEPTH(TAPE_DEPTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .operation_i,
    .amount_i,
    .jump_target_i,
    .input_byte_i,
    .s1_ready_i (s1_ready),
    .s1_valid_o (s1_valid),
    .s1_o       (s1),
    .s1_ptr_o   (s1_ptr),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .clearing_o (clearing),
    .clr_addr_o (clr_addr)
  );

  assign ram_we    = clearing || ex_we;
  assign ram_waddr = clearing ? clr_addr : ex_waddr;
  assign ram_wdata = clearing ? 8'h00 : ex_wdata;

  bbe_ram #(
    .WIDTH(8),
    .DEPTH(TAPE_DEPTH)
  ) u_tape (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  bbe_exec #(
    .TAPE_DEPTH   (TAPE_DEPTH),
    .PROGRAM_DEPTH(PROGRAM_DEPTH)
  ) u_exec (
    .clk_i,
    .rst_ni,
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_i       (s1),
    .s1_ptr_i   (s1_ptr),
    .rd_data_i  (rd_data),
    .wr_en_o    (ex_we),
    .wr_addr_o  (ex_waddr),
    .wr_data_o  (ex_wdata),
    .res_valid_o,
    .res_ready_i,
    .next_address_o,
    .out_byte_o,
    .out_valid_o,
    .range_error_o,
    .status_o
  );

  `BBE_ASSERT_IMP(a_no_accept_clr, clk_i, rst_ni, clearing, !in_ready_o)
  `BBE_ASSERT_IMP(a_no_exec_wr_clr, clk_i, rst_ni, clearing, !ex_we && !s1_valid)
  `BBE_ASSERT_IMP(a_emit_runs, clk_i, rst_ni, res_valid_o && out_valid_o, status_o == ST_RUN && !range_error_o)
  `BBE_ASSERT_NXT(a_accept_fills_s1, clk_i, rst_ni, in_valid_i && in_ready_o, s1_valid)

endmodule

`default_nettype wire
